[hw/rtl/gcd_pkg.sv]
package gcd_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;

    // Angle and CORDIC datapath words.
    typedef logic signed [32:0] angle_t;
    typedef logic signed [33:0] cordic_t;

    // Register indexes, taken from paddr[2].
    localparam logic REG_TARGET_LAT = 1'b0;
    localparam logic REG_TARGET_LON = 1'b1;

    localparam logic [32:0]    DEG_TO_Q62     = 33'd8048910509;
    localparam cordic_t        CORDIC_GAIN    = 34'sd652032874;
    localparam logic [32:0]    FULL_TURN_DIFF = 33'd3600000000;
    localparam logic [32:0]    HALF_TURN_DIFF = 33'd1800000000;
    localparam logic [30:0]    STRAIGHT_ANGLE = 31'd1800000000;
    localparam logic [30:0]    RIGHT_ANGLE    = 31'd900000000;
    localparam logic [30:0]    ONE_Q30        = 31'h40000000;
    localparam logic [22:0]    EARTH_RADIUS_M = 23'd6371000;
    localparam logic [24:0]    MAX_DISTANCE   = 25'd20015087;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        case (i)
            0:       v = 30'h3243F6A8;
            1:       v = 30'h1DAC6705;
            2:       v = 30'h0FADBAFC;
            3:       v = 30'h07F56EA6;
            4:       v = 30'h03FEAB76;
            5:       v = 30'h01FFD55B;
            6:       v = 30'h00FFFAAA;
            7:       v = 30'h007FFF55;
            8:       v = 30'h003FFFEA;
            9:       v = 30'h001FFFFD;
            10:      v = 30'h000FFFFF;
            11:      v = 30'h0007FFFF;
            12:      v = 30'h0003FFFF;
            13:      v = 30'h0001FFFF;
            14:      v = 30'h0000FFFF;
            15:      v = 30'h00007FFF;
            16:      v = 30'h00003FFF;
            17:      v = 30'h00001FFF;
            18:      v = 30'h00000FFF;
            19:      v = 30'h000007FF;
            20:      v = 30'h000003FF;
            21:      v = 30'h000001FF;
            22:      v = 30'h000000FF;
            23:      v = 30'h0000007F;
            24:      v = 30'h0000003F;
            25:      v = 30'h0000001F;
            26:      v = 30'h0000000F;
            27:      v = 30'h00000008;
            28:      v = 30'h00000004;
            29:      v = 30'h00000002;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // Product of two Q30 values, rounded by adding half an LSB and flooring.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b)) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

[hw/rtl/gcd_rot.sv]
module gcd_rot
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  gcd_pkg::angle_t  in_angle,
    input  logic             in_neg,
    output logic             out_valid,
    output gcd_pkg::cordic_t out_cos,
    output gcd_pkg::cordic_t out_sin
);

    localparam int N = gcd_pkg::CORDIC_STEPS;

    gcd_pkg::cordic_t x_reg [0:N];
    gcd_pkg::cordic_t y_reg [0:N];
    gcd_pkg::angle_t  z_reg [0:N];
    logic             neg_reg [0:N];
    logic             valid_reg [0:N+1];
    gcd_pkg::cordic_t cos_reg;
    gcd_pkg::cordic_t sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N + 1; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i <= N; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= gcd_pkg::CORDIC_GAIN;
        y_reg[0]   <= '0;
        z_reg[0]   <= in_angle;
        neg_reg[0] <= in_neg;
        for (int i = 0; i < N; i++)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (!z_reg[i][32])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - $signed({3'b000, gcd_pkg::atan_q30(i)});
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + $signed({3'b000, gcd_pkg::atan_q30(i)});
            end
        end
        // Cosine of an angle folded past a right angle takes its sign here.
        cos_reg <= neg_reg[N] ? -x_reg[N] : x_reg[N];
        sin_reg <= y_reg[N];
    end

    assign out_valid = valid_reg[N+1];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

[hw/rtl/gcd_sqrt.sv]
module gcd_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [60:0] in_value,
    output logic        out_valid,
    output logic [30:0] out_root
);

    localparam int N = gcd_pkg::SQRT_STEPS;

    logic [61:0] v_reg [0:N];
    logic [61:0] r_reg [0:N];
    logic [61:0] v_next [0:N-1];
    logic [61:0] r_next [0:N-1];
    logic        valid_reg [0:N];

    // One result bit per stage, from the top pair of bits down.
    always_comb
    begin
        logic [61:0] bit_val;
        logic [61:0] trial;
        for (int j = 0; j < N; j++)
        begin
            bit_val = 62'(1) << (2 * (N - 1 - j));
            trial   = r_reg[j] + bit_val;
            if (v_reg[j] >= trial)
            begin
                v_next[j] = v_reg[j] - trial;
                r_next[j] = (r_reg[j] >> 1) + bit_val;
            end
            else
            begin
                v_next[j] = v_reg[j];
                r_next[j] = r_reg[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= N; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int j = 0; j < N; j++)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg[0] <= {1'b0, in_value};
        r_reg[0] <= '0;
        for (int j = 0; j < N; j++)
        begin
            v_reg[j+1] <= v_next[j];
            r_reg[j+1] <= r_next[j];
        end
    end

    assign out_valid = valid_reg[N];
    assign out_root  = r_reg[N][30:0];

endmodule

[hw/rtl/great_circle_distance.sv]
// Haversine distance from the current position to the programmed target.
// done strobes after the front end, rotations, products, roots, vectoring and scaling.
// Throughput: one position per cycle; busy stays low and done is a one-cycle pulse.
// The depth is set by the three CORDIC and square-root pipelines, one step per stage.
// Reset clears the target registers to zero and empties the pipeline.
module great_circle_distance
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] current_latitude,
    input  logic signed [31:0] current_longitude,
    output logic               done,
    output logic [24:0]        distance_m
);

    localparam int NV = gcd_pkg::CORDIC_STEPS;

    logic signed [30:0] tlat_reg;
    logic signed [31:0] tlon_reg;

    // Front end: differences, magnitudes, folding, conversion to radians.
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [32:0] dlat1_reg, dlon1_reg;
    logic signed [30:0] la1_1_reg, la2_1_reg;
    logic [32:0]        mdlat2_reg, mdlon2_reg;
    logic [30:0]        mla1_2_reg, mla2_2_reg;
    logic [30:0]        mdlat3_reg, mdlon3_reg, mla1_3_reg, mla2_3_reg;
    logic               flip1_3_reg, flip2_3_reg;
    gcd_pkg::angle_t    zdlat4_reg, zdlon4_reg, zla1_4_reg, zla2_4_reg;
    logic               flip1_4_reg, flip2_4_reg;

    logic               rot_valid;
    gcd_pkg::cordic_t   cos_dlat, sin_dlat, cos_dlon, sin_dlon;
    gcd_pkg::cordic_t   cos_la1, sin_la1, cos_la2, sin_la2;

    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic signed [31:0] sslat1_reg, sslon1_reg, cc1_reg;
    logic signed [31:0] sslat2_reg, t2_reg;
    logic [30:0]        a3_reg, b3_reg;

    logic               sqrt_valid;
    logic [30:0]        root_s, root_t;

    gcd_pkg::cordic_t   vx_reg [0:NV];
    gcd_pkg::cordic_t   vy_reg [0:NV];
    gcd_pkg::angle_t    vz_reg [0:NV];
    logic               vvalid_reg [0:NV];

    logic               f1_valid_reg;
    logic [26:0]        draw_reg;
    logic               done_reg;
    logic [24:0]        distance_reg;

    logic               cfg_write;
    logic signed [32:0] dlat_next, dlon_next;
    logic [32:0]        mod_dlat, mod_dlon;
    logic [63:0]        rad_dlat, rad_dlon, rad_la1, rad_la2;
    logic signed [32:0] asum;
    logic [31:0]        c_pos;
    logic [56:0]        dprod;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == gcd_pkg::REG_TARGET_LAT) ? {1'b0, tlat_reg} : tlon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlat_reg <= '0;
            tlon_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                gcd_pkg::REG_TARGET_LAT: tlat_reg <= pwdata[30:0];
                gcd_pkg::REG_TARGET_LON: tlon_reg <= pwdata;
                default:                 tlon_reg <= tlon_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    assign dlat_next = 33'(tlat_reg) - 33'(current_latitude);
    assign dlon_next = 33'(tlon_reg) - 33'(current_longitude);

    // sin^2 is even and periodic in 360 degrees of difference, so only the
    // folded magnitude matters.
    always_comb
    begin
        mod_dlat = (mdlat2_reg >= gcd_pkg::FULL_TURN_DIFF) ?
                   mdlat2_reg - gcd_pkg::FULL_TURN_DIFF : mdlat2_reg;
        mod_dlon = (mdlon2_reg >= gcd_pkg::FULL_TURN_DIFF) ?
                   mdlon2_reg - gcd_pkg::FULL_TURN_DIFF : mdlon2_reg;
        if (mod_dlat > gcd_pkg::HALF_TURN_DIFF)
        begin
            mod_dlat = gcd_pkg::FULL_TURN_DIFF - mod_dlat;
        end
        if (mod_dlon > gcd_pkg::HALF_TURN_DIFF)
        begin
            mod_dlon = gcd_pkg::FULL_TURN_DIFF - mod_dlon;
        end
    end

    assign rad_dlat = 64'(mdlat3_reg) * 64'(gcd_pkg::DEG_TO_Q62) + 64'h1_0000_0000;
    assign rad_dlon = 64'(mdlon3_reg) * 64'(gcd_pkg::DEG_TO_Q62) + 64'h1_0000_0000;
    assign rad_la1  = 64'(mla1_3_reg) * 64'(gcd_pkg::DEG_TO_Q62) + 64'h8000_0000;
    assign rad_la2  = 64'(mla2_3_reg) * 64'(gcd_pkg::DEG_TO_Q62) + 64'h8000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i <= NV; i++)
            begin
                vvalid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg        <= start && !busy;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            p1_valid_reg  <= rot_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            vvalid_reg[0] <= sqrt_valid;
            for (int i = 0; i < NV; i++)
            begin
                vvalid_reg[i+1] <= vvalid_reg[i];
            end
            f1_valid_reg  <= vvalid_reg[NV];
            done_reg      <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dlat1_reg   <= dlat_next;
        dlon1_reg   <= dlon_next;
        la1_1_reg   <= current_latitude;
        la2_1_reg   <= tlat_reg;

        mdlat2_reg  <= dlat1_reg[32] ? 33'(-dlat1_reg) : 33'(dlat1_reg);
        mdlon2_reg  <= dlon1_reg[32] ? 33'(-dlon1_reg) : 33'(dlon1_reg);
        mla1_2_reg  <= la1_1_reg[30] ? 31'(-la1_1_reg) : 31'(la1_1_reg);
        mla2_2_reg  <= la2_1_reg[30] ? 31'(-la2_1_reg) : 31'(la2_1_reg);

        mdlat3_reg  <= mod_dlat[30:0];
        mdlon3_reg  <= mod_dlon[30:0];
        flip1_3_reg <= mla1_2_reg > gcd_pkg::RIGHT_ANGLE;
        flip2_3_reg <= mla2_2_reg > gcd_pkg::RIGHT_ANGLE;
        mla1_3_reg  <= (mla1_2_reg > gcd_pkg::RIGHT_ANGLE) ?
                       gcd_pkg::STRAIGHT_ANGLE - mla1_2_reg : mla1_2_reg;
        mla2_3_reg  <= (mla2_2_reg > gcd_pkg::RIGHT_ANGLE) ?
                       gcd_pkg::STRAIGHT_ANGLE - mla2_2_reg : mla2_2_reg;

        // Half differences convert with one more bit of shift.
        zdlat4_reg  <= $signed({2'b00, rad_dlat[63:33]});
        zdlon4_reg  <= $signed({2'b00, rad_dlon[63:33]});
        zla1_4_reg  <= $signed({1'b0, rad_la1[63:32]});
        zla2_4_reg  <= $signed({1'b0, rad_la2[63:32]});
        flip1_4_reg <= flip1_3_reg;
        flip2_4_reg <= flip2_3_reg;
    end

    gcd_rot u_rot_dlat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_angle  (zdlat4_reg),
        .in_neg    (1'b0),
        .out_valid (rot_valid),
        .out_cos   (cos_dlat),
        .out_sin   (sin_dlat)
    );

    gcd_rot u_rot_dlon
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_angle  (zdlon4_reg),
        .in_neg    (1'b0),
        .out_valid (),
        .out_cos   (cos_dlon),
        .out_sin   (sin_dlon)
    );

    gcd_rot u_rot_la1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_angle  (zla1_4_reg),
        .in_neg    (flip1_4_reg),
        .out_valid (),
        .out_cos   (cos_la1),
        .out_sin   (sin_la1)
    );

    gcd_rot u_rot_la2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_angle  (zla2_4_reg),
        .in_neg    (flip2_4_reg),
        .out_valid (),
        .out_cos   (cos_la2),
        .out_sin   (sin_la2)
    );

    // Haversine term, clamped to [0, 1] before the roots.
    assign asum = 33'(sslat2_reg) + 33'(t2_reg);

    always_ff @(posedge clk)
    begin
        sslat1_reg <= gcd_pkg::qmul(sin_dlat[31:0], sin_dlat[31:0]);
        sslon1_reg <= gcd_pkg::qmul(sin_dlon[31:0], sin_dlon[31:0]);
        cc1_reg    <= gcd_pkg::qmul(cos_la1[31:0], cos_la2[31:0]);

        sslat2_reg <= sslat1_reg;
        t2_reg     <= gcd_pkg::qmul(sslon1_reg, cc1_reg);

        if (asum[32])
        begin
            a3_reg <= '0;
            b3_reg <= gcd_pkg::ONE_Q30;
        end
        else if (asum > 33'(gcd_pkg::ONE_Q30))
        begin
            a3_reg <= gcd_pkg::ONE_Q30;
            b3_reg <= '0;
        end
        else
        begin
            a3_reg <= asum[30:0];
            b3_reg <= gcd_pkg::ONE_Q30 - asum[30:0];
        end
    end

    gcd_sqrt u_sqrt_a
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_valid_reg),
        .in_value  ({a3_reg, 30'b0}),
        .out_valid (sqrt_valid),
        .out_root  (root_s)
    );

    gcd_sqrt u_sqrt_b
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_valid_reg),
        .in_value  ({b3_reg, 30'b0}),
        .out_valid (),
        .out_root  (root_t)
    );

    // atan2 by vectoring, one step per stage.
    always_ff @(posedge clk)
    begin
        vx_reg[0] <= $signed({3'b000, root_t});
        vy_reg[0] <= $signed({3'b000, root_s});
        vz_reg[0] <= '0;
        for (int i = 0; i < NV; i++)
        begin
            if (vy_reg[i] > 0)
            begin
                vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] + $signed({3'b000, gcd_pkg::atan_q30(i)});
            end
            else
            begin
                vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                vz_reg[i+1] <= vz_reg[i] - $signed({3'b000, gcd_pkg::atan_q30(i)});
            end
        end
    end

    // Central angle is twice the arctangent; a negative angle counts as zero.
    assign c_pos = vz_reg[NV][32] ? 32'd0 : {vz_reg[NV][30:0], 1'b0};
    assign dprod = 57'(c_pos) * 57'(gcd_pkg::EARTH_RADIUS_M) + 57'd536870912;

    always_ff @(posedge clk)
    begin
        draw_reg     <= dprod[56:30];
        distance_reg <= (draw_reg > 27'(gcd_pkg::MAX_DISTANCE)) ?
                        gcd_pkg::MAX_DISTANCE : draw_reg[24:0];
    end

    assign done       = done_reg;
    assign distance_m = distance_reg;

endmodule
